// ----- rtl/pnpls_pkg.sv -----
package pnpls_pkg;

    localparam int NODE_W = 4;
    localparam int TRAV_W = 4;
    localparam int COST_W = 16;
    localparam int KEY_W  = 32;

    localparam logic ACT_REQUEST = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    localparam logic MODE_FCFS = 1'b0;
    localparam logic MODE_SJF  = 1'b1;

    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [TRAV_W-1:0] trav_t;
    typedef logic [NODE_W-1:0] node_t;
    typedef logic [COST_W-1:0] cost_t;

    typedef struct packed {
        trav_t requester;
        key_t  key;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROC,
        ST_SCAN,
        ST_SHIFT,
        ST_FIN
    } state_t;

endpackage

// ----- rtl/per_node_priority_lock_scheduler.sv -----
// Per-node priority lock scheduler.
//
// Request channel (req_valid / req_stall): one item per transfer, carrying
// action (request or release), node, traveler and cost. Response channel
// (rsp_valid / rsp_stall): exactly one result per item, carrying granted,
// granted_node, granted_traveler and dropped. sched_mode is written through
// cfg_wr_en / cfg_wr_data; the user writes it only while the block is idle, which the block itself does not enforce.
//
// When no grant is made (out-of-range node, busy node or empty wait list) the
// item goes from the process state straight to the final state. A grant scans the
// node's n waiters through the single read port of the wait-list memory and
// then closes the gap behind the winner, one entry per cycle through the same
// port pair. req_stall is high from the transfer until the result loads, so a
// new item is not taken before the last one's result is in the response register.
//
// The response register lets the next request transfer while a result still
// waits; a stalled result holds until taken and a new result waits in the
// final state for it. Reset clears wait counts, busy marks, the arrival
// counter and the mode; wait-list memory contents are not cleared.
module per_node_priority_lock_scheduler #(
    parameter int NUM_NODES     = 16,
    parameter int NUM_TRAVELERS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,

    input  logic                 req_valid,
    output logic                 req_stall,
    input  logic                 action,
    input  pnpls_pkg::node_t     node,
    input  pnpls_pkg::trav_t     traveler,
    input  pnpls_pkg::cost_t     cost,

    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output logic                 granted,
    output pnpls_pkg::node_t     granted_node,
    output pnpls_pkg::trav_t     granted_traveler,
    output logic                 dropped
);
    import pnpls_pkg::*;

    localparam int NW    = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
    localparam int SW    = (NUM_TRAVELERS > 1) ? $clog2(NUM_TRAVELERS) : 1;
    localparam int CW    = $clog2(NUM_TRAVELERS + 1);
    localparam int AW    = NW + SW;
    localparam int DEPTH = 1 << AW;

    typedef logic [CW-1:0] cnt_t;

    // control state
    state_t              state_reg, state_next;
    logic                sched_mode_reg;
    key_t                arrival_reg, arrival_next;
    cnt_t                cnt_reg [NUM_NODES];
    logic [NUM_NODES-1:0] busy_reg;
    logic                rd_vld_reg, rd_vld_next;
    logic                rsp_valid_reg, rsp_valid_next;

    // payload
    logic                act_reg, act_next;
    node_t               node_reg, node_next;
    logic [NW-1:0]       nd_reg, nd_next;
    logic                oor_reg, oor_next;
    trav_t               trav_reg, trav_next;
    cost_t               cost_reg, cost_next;
    cnt_t                n_reg, n_next;
    cnt_t                ri_reg, ri_next;
    cnt_t                rd_idx_reg, rd_idx_next;
    cnt_t                best_idx_reg, best_idx_next;
    key_t                best_key_reg, best_key_next;
    trav_t               best_trav_reg, best_trav_next;
    logic                res_granted_reg, res_granted_next;
    logic                res_dropped_reg, res_dropped_next;
    logic                out_granted_reg, out_granted_next;
    node_t               out_node_reg, out_node_next;
    trav_t               out_trav_reg, out_trav_next;
    logic                out_dropped_reg, out_dropped_next;

    // wait-list memory
    entry_t              wait_mem [DEPTH];
    entry_t              rd_data_reg;
    logic                mem_we;
    logic [AW-1:0]       mem_wa;
    entry_t              mem_wd;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;

    // count / busy write port
    logic                cnt_we;
    cnt_t                cnt_wd;
    logic                busy_we;
    logic                busy_wd;

    cnt_t                cur_cnt;
    logic                cur_busy;
    cnt_t                n_new;
    logic                busy_new;
    logic                take;
    cnt_t                final_idx;
    cnt_t                wr_idx;
    cnt_t                n_dec;
    logic [NW+NODE_W-1:0] node_ext;
    logic [8:0]          node_cmp;
    key_t                new_key;

    assign cur_cnt  = cnt_reg[nd_reg];
    assign cur_busy = busy_reg[nd_reg];
    assign node_ext = (NW + NODE_W)'(node);
    assign node_cmp = 9'(node);
    assign new_key  = (sched_mode_reg == MODE_SJF) ? KEY_W'(cost_reg) : arrival_reg;
    assign wr_idx   = rd_idx_reg - CW'(1);
    assign n_dec    = n_reg - CW'(1);

    always_comb
    begin
        state_next       = state_reg;
        arrival_next     = arrival_reg;
        rd_vld_next      = rd_vld_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        act_next         = act_reg;
        node_next        = node_reg;
        nd_next          = nd_reg;
        oor_next         = oor_reg;
        trav_next        = trav_reg;
        cost_next        = cost_reg;
        n_next           = n_reg;
        ri_next          = ri_reg;
        rd_idx_next      = rd_idx_reg;
        best_idx_next    = best_idx_reg;
        best_key_next    = best_key_reg;
        best_trav_next   = best_trav_reg;
        res_granted_next = res_granted_reg;
        res_dropped_next = res_dropped_reg;
        out_granted_next = out_granted_reg;
        out_node_next    = out_node_reg;
        out_trav_next    = out_trav_reg;
        out_dropped_next = out_dropped_reg;
        mem_we           = 1'b0;
        mem_wa           = '0;
        mem_wd           = '0;
        rd_en            = 1'b0;
        rd_addr          = '0;
        cnt_we           = 1'b0;
        cnt_wd           = cur_cnt;
        busy_we          = 1'b0;
        busy_wd          = 1'b0;
        n_new            = cur_cnt;
        busy_new         = cur_busy;
        take             = 1'b0;
        final_idx        = best_idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    act_next   = action;
                    node_next  = node;
                    nd_next    = node_ext[NW-1:0];
                    oor_next   = (node_cmp >= 9'(NUM_NODES));
                    trav_next  = traveler;
                    cost_next  = cost;
                    state_next = ST_PROC;
                end
            end

            ST_PROC:
            begin
                res_granted_next = 1'b0;
                res_dropped_next = 1'b0;
                rd_vld_next      = 1'b0;
                ri_next          = '0;
                if (oor_reg)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    if (act_reg == ACT_REQUEST)
                    begin
                        if (cur_cnt == CW'(NUM_TRAVELERS))
                        begin
                            res_dropped_next = 1'b1;
                        end
                        else
                        begin
                            mem_we = 1'b1;
                            mem_wa = {nd_reg, cur_cnt[SW-1:0]};
                            mem_wd = '{requester: trav_reg, key: new_key};
                            n_new  = cur_cnt + CW'(1);
                            if (sched_mode_reg == MODE_FCFS)
                                arrival_next = arrival_reg + KEY_W'(1);
                        end
                    end
                    else
                    begin
                        busy_new = 1'b0;
                    end
                    cnt_we  = 1'b1;
                    cnt_wd  = n_new;
                    busy_we = 1'b1;
                    busy_wd = busy_new;
                    n_next  = n_new;
                    if (n_new == '0 || busy_new)
                        state_next = ST_FIN;
                    else
                        state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (ri_reg < n_reg)
                begin
                    rd_en       = 1'b1;
                    rd_addr     = {nd_reg, ri_reg[SW-1:0]};
                    ri_next     = ri_reg + CW'(1);
                    rd_vld_next = 1'b1;
                    rd_idx_next = ri_reg;
                end
                else
                begin
                    rd_vld_next = 1'b0;
                end
                if (rd_vld_reg)
                begin
                    // strict less-than keeps the earliest entry on ties
                    take = (rd_idx_reg == '0) || (rd_data_reg.key < best_key_reg);
                    if (take)
                    begin
                        best_idx_next  = rd_idx_reg;
                        best_key_next  = rd_data_reg.key;
                        best_trav_next = rd_data_reg.requester;
                        final_idx      = rd_idx_reg;
                    end
                    if (rd_idx_reg == n_dec)
                    begin
                        ri_next     = final_idx + CW'(1);
                        rd_vld_next = 1'b0;
                        state_next  = ST_SHIFT;
                    end
                end
            end

            ST_SHIFT:
            begin
                if (ri_reg < n_reg)
                begin
                    rd_en       = 1'b1;
                    rd_addr     = {nd_reg, ri_reg[SW-1:0]};
                    ri_next     = ri_reg + CW'(1);
                    rd_vld_next = 1'b1;
                    rd_idx_next = ri_reg;
                end
                else
                begin
                    rd_vld_next = 1'b0;
                end
                if (rd_vld_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = {nd_reg, wr_idx[SW-1:0]};
                    mem_wd = rd_data_reg;
                end
                if (!(ri_reg < n_reg) && !rd_vld_reg)
                begin
                    cnt_we           = 1'b1;
                    cnt_wd           = n_dec;
                    busy_we          = 1'b1;
                    busy_wd          = 1'b1;
                    res_granted_next = 1'b1;
                    state_next       = ST_FIN;
                end
            end

            ST_FIN:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next   = 1'b1;
                    out_granted_next = res_granted_reg;
                    out_node_next    = res_granted_reg ? node_reg : '0;
                    out_trav_next    = res_granted_reg ? best_trav_reg : '0;
                    out_dropped_next = res_dropped_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sched_mode_reg <= MODE_FCFS;
            arrival_reg    <= '0;
            busy_reg       <= '0;
            rd_vld_reg     <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_NODES; i++)
                cnt_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            arrival_reg   <= arrival_next;
            rd_vld_reg    <= rd_vld_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
                sched_mode_reg <= cfg_wr_data;
            if (cnt_we)
                cnt_reg[nd_reg] <= cnt_wd;
            if (busy_we)
                busy_reg[nd_reg] <= busy_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg         <= act_next;
        node_reg        <= node_next;
        nd_reg          <= nd_next;
        oor_reg         <= oor_next;
        trav_reg        <= trav_next;
        cost_reg        <= cost_next;
        n_reg           <= n_next;
        ri_reg          <= ri_next;
        rd_idx_reg      <= rd_idx_next;
        best_idx_reg    <= best_idx_next;
        best_key_reg    <= best_key_next;
        best_trav_reg   <= best_trav_next;
        res_granted_reg <= res_granted_next;
        res_dropped_reg <= res_dropped_next;
        out_granted_reg <= out_granted_next;
        out_node_reg    <= out_node_next;
        out_trav_reg    <= out_trav_next;
        out_dropped_reg <= out_dropped_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            wait_mem[mem_wa] <= mem_wd;
        if (rd_en)
            rd_data_reg <= wait_mem[rd_addr];
    end

    assign req_stall        = (state_reg != ST_IDLE);
    assign rsp_valid        = rsp_valid_reg;
    assign granted          = out_granted_reg;
    assign granted_node     = out_node_reg;
    assign granted_traveler = out_trav_reg;
    assign dropped          = out_dropped_reg;

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN || state_reg == ST_SHIFT) && rd_vld_reg)
            |-> (rd_idx_reg < n_reg))
        else $error("wait-list read beyond node count");

    a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> (best_idx_reg < n_reg))
        else $error("selected waiter beyond node count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (n_reg != '0 && n_reg <= CW'(NUM_TRAVELERS)))
        else $error("scan started with invalid count");

    a_grant_not_drop_release: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && res_dropped_reg) |-> (act_reg == ACT_REQUEST))
        else $error("drop flagged on a release");

    a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !rd_vld_reg)
        else $error("read pipeline busy while idle");

endmodule
